// ===== rtl/core/mrte_pkg.sv =====
// Shared types and constants for the memory region table engine.
package mrte_pkg;

  // Action codes carried on the input beat.
  localparam logic [2:0] ACT_CLEAR  = 3'd0;
  localparam logic [2:0] ACT_APPEND = 3'd1;
  localparam logic [2:0] ACT_CARVE  = 3'd2;
  localparam logic [2:0] ACT_SORT   = 3'd3;
  localparam logic [2:0] ACT_FIND   = 3'd4;

  // Configuration register indexes.
  localparam logic CFG_RAM_TYPE  = 1'b0;
  localparam logic CFG_RSVD_TYPE = 1'b1;

  // One table entry.
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] length;
    logic [7:0]  rtype;
  } entry_t;

  // Command that every cell carries out.
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROT,
    CELL_LOAD,
    CELL_SORT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      phase;
  } cell_ctl_t;

  // Per-step findings of the head unit.
  typedef struct packed {
    logic        split;
    logic [63:0] split_base;
    logic [63:0] split_len;
    logic        match;
    logic [63:0] match_addr;
  } head_res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CARVE,
    ST_FIND,
    ST_SORT,
    ST_SPLIT
  } state_t;

endpackage

// ===== rtl/core/mrte_cell.sv =====
// One table cell: holds an entry, rotates, loads or swaps with a neighbor.
module mrte_cell #(
  parameter int IDX         = 0,
  parameter int CW          = 6
) (
  input  logic               clk,
  input  mrte_pkg::cell_ctl_t ctl_i,
  input  logic [CW-1:0]      count_i,
  input  mrte_pkg::entry_t   prev_i,
  input  mrte_pkg::entry_t   next_i,
  input  mrte_pkg::entry_t   load_i,
  output mrte_pkg::entry_t   entry_o
);

  localparam logic [CW:0] MY_POS   = (CW+1)'(IDX);
  localparam logic [CW:0] NEXT_POS = (CW+1)'(IDX + 1);
  localparam logic        IDX_ODD  = 1'(IDX % 2);

  mrte_pkg::entry_t ent_r;
  mrte_pkg::entry_t ent_nxt;
  logic             is_low;
  logic             pair_on;
  logic             swap;

  // Odd-even transposition: pick partner for this phase.
  always_comb begin
    is_low  = (IDX_ODD == ctl_i.phase);
    if (is_low) begin
      pair_on = NEXT_POS < {1'b0, count_i};
      swap    = ent_r.base > next_i.base;
    end else begin
      pair_on = (IDX >= 1) && (MY_POS < {1'b0, count_i});
      swap    = prev_i.base > ent_r.base;
    end
  end

  // Next content of the cell.
  always_comb begin
    ent_nxt = ent_r;
    case (ctl_i.cmd)
      mrte_pkg::CELL_ROT: ent_nxt = next_i;
      mrte_pkg::CELL_LOAD: begin
        if (MY_POS == {1'b0, count_i}) ent_nxt = load_i;
      end
      mrte_pkg::CELL_SORT: begin
        if (pair_on && swap) ent_nxt = is_low ? next_i : prev_i;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

  assign entry_o = ent_r;

endmodule

// ===== rtl/core/mrte_head.sv =====
// Head unit: carve edit and find test for the entry leaving cell zero.
module mrte_head #(
  parameter int PAGE_BITS = 12
) (
  input  mrte_pkg::entry_t  entry_i,
  input  logic              valid_i,
  input  logic              carve_i,
  input  logic [63:0]       start_i,
  input  logic [63:0]       end_i,
  input  logic [7:0]        ram_type_i,
  input  logic [7:0]        rsvd_type_i,
  input  logic [63:0]       rlo_i,
  input  logic [63:0]       rhi_i,
  input  logic [63:0]       rsz_i,
  output mrte_pkg::entry_t  entry_o,
  output mrte_pkg::head_res_t res_o
);

  localparam logic [63:0] PG_MASK = (64'(1) << PAGE_BITS) - 64'(1);

  logic [63:0] es, ee, st, en, flen, lim;
  logic        is_ram, hit, lt_s, le_e, fit;

  always_comb begin
    es     = entry_i.base;
    ee     = entry_i.base + entry_i.length;
    is_ram = entry_i.rtype == ram_type_i;
    lt_s   = es < start_i;
    le_e   = ee <= end_i;
    hit    = valid_i && carve_i && is_ram && !(ee <= start_i) && !(es >= end_i);

    // Carve: trim, reserve, cut the head, or split.
    entry_o           = entry_i;
    res_o.split       = 1'b0;
    res_o.split_base  = end_i;
    res_o.split_len   = ee - end_i;
    if (hit) begin
      if (lt_s) begin
        entry_o.length = start_i - es;
        res_o.split    = !le_e;
      end else if (le_e) begin
        entry_o.rtype = rsvd_type_i;
      end else begin
        entry_o.base   = end_i;
        entry_o.length = ee - end_i;
      end
    end

    // Find: page-aligned usable span of this entry inside the window.
    st   = (es + PG_MASK) & ~PG_MASK;
    en   = ee & ~PG_MASK;
    flen = (en > st) ? (en - st) : 64'd0;
    lim  = (en < rhi_i) ? en : rhi_i;
    fit  = ((st >= start_i) && (st + rsz_i <= lim)) ||
           ((st < start_i) && (start_i + rsz_i <= lim));
    res_o.match      = valid_i && !carve_i && is_ram && (flen >= rsz_i) &&
                       (en > rlo_i) && (st < rhi_i) && fit;
    res_o.match_addr = (en > rhi_i) ? (rhi_i - rsz_i) : (en - rsz_i);
  end

endmodule

// ===== rtl/core/memory_region_table_engine_core.sv =====
// Top level of the memory region table engine: control, cell row and head unit.
//
// Channel | Direction | Beat content
// in_     | input     | action, entry fields, range, request size
// out_    | output    | found, space address, entry total, overflow
// cfg_    | input     | register write, no wait
//
// Clear, append and unused actions give their result straight from the idle state.
// Carve, find and sort keep the engine busy while the row of cells rotates once past
// the head unit, or runs MAX_ENTRIES sort phases; carve then adds any split-off tail.
// One item is in work at a time; a new beat is taken once the result is delivered.
// Reset is synchronous; table contents are not cleared, only the entry count.
module memory_region_table_engine_core #(
  parameter int MAX_ENTRIES = 32,
  parameter int PAGE_BITS   = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_action,
  input  logic [63:0] in_entry_base,
  input  logic [63:0] in_entry_length,
  input  logic [7:0]  in_entry_type,
  input  logic [63:0] in_range_start,
  input  logic [63:0] in_range_end,
  input  logic [31:0] in_request_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_found,
  output logic [63:0] out_space_address,
  output logic [5:0]  out_entry_total,
  output logic        out_overflow,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int          CW      = $clog2(MAX_ENTRIES + 1);
  localparam logic [63:0] PG_MASK = (64'(1) << PAGE_BITS) - 64'(1);
  localparam logic [CW-1:0] LAST_STEP = CW'(MAX_ENTRIES - 1);
  localparam logic [CW-1:0] FULL      = CW'(MAX_ENTRIES);

  mrte_pkg::state_t    state_r, state_nxt;
  logic [7:0]          ram_type_r, rsvd_type_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       step_r, step_nxt;
  logic [63:0]         start_r, end_r, rlo_r, rhi_r, rsz_r;
  logic [63:0]         nb_r, nb_nxt, nl_r, nl_nxt;
  logic                found_r, found_nxt;
  logic [63:0]         addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [63:0]         out_addr_r, out_addr_nxt;
  logic [5:0]          out_total_r, out_total_nxt;
  logic                out_ovf_r, out_ovf_nxt;
  logic                in_fire, last;
  logic                fin, fin_found, fin_ovf;
  logic [63:0]         fin_addr;

  mrte_pkg::cell_ctl_t ctl;
  mrte_pkg::entry_t    load_ent;
  mrte_pkg::entry_t    cells [MAX_ENTRIES];
  mrte_pkg::entry_t    head_out;
  mrte_pkg::head_res_t head_res;

  assign in_ready = (state_r == mrte_pkg::ST_IDLE) && !out_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign last     = step_r == LAST_STEP;

  // Row of cells; the last one takes the entry back from the head unit.
  for (genvar k = 0; k < MAX_ENTRIES; k++) begin : g_cell
    mrte_pkg::entry_t prev_e, next_e;
    assign prev_e = (k == 0) ? cells[k] : cells[(k + MAX_ENTRIES - 1) % MAX_ENTRIES];
    assign next_e = (k == MAX_ENTRIES - 1) ? head_out : cells[(k + 1) % MAX_ENTRIES];
    mrte_cell #(
      .IDX        (k),
      .CW         (CW)
    ) u_cell (
      .clk    (clk),
      .ctl_i  (ctl),
      .count_i(count_r),
      .prev_i (prev_e),
      .next_i (next_e),
      .load_i (load_ent),
      .entry_o(cells[k])
    );
  end

  mrte_head #(
    .PAGE_BITS(PAGE_BITS)
  ) u_head (
    .entry_i    (cells[0]),
    .valid_i    (step_r < count_r),
    .carve_i    (state_r == mrte_pkg::ST_CARVE),
    .start_i    (start_r),
    .end_i      (end_r),
    .ram_type_i (ram_type_r),
    .rsvd_type_i(rsvd_type_r),
    .rlo_i      (rlo_r),
    .rhi_i      (rhi_r),
    .rsz_i      (rsz_r),
    .entry_o    (head_out),
    .res_o      (head_res)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mrte_pkg::ST_IDLE: begin
        if (in_fire) begin
          unique case (in_action)
            mrte_pkg::ACT_CARVE: state_nxt = mrte_pkg::ST_CARVE;
            mrte_pkg::ACT_SORT:  state_nxt = mrte_pkg::ST_SORT;
            mrte_pkg::ACT_FIND:  state_nxt = mrte_pkg::ST_FIND;
            default:             state_nxt = mrte_pkg::ST_IDLE;
          endcase
        end
      end
      mrte_pkg::ST_CARVE: if (last) state_nxt = mrte_pkg::ST_SPLIT;
      mrte_pkg::ST_FIND:  if (last) state_nxt = mrte_pkg::ST_IDLE;
      mrte_pkg::ST_SORT:  if (last) state_nxt = mrte_pkg::ST_IDLE;
      mrte_pkg::ST_SPLIT: state_nxt = mrte_pkg::ST_IDLE;
      default:            state_nxt = mrte_pkg::ST_IDLE;
    endcase
  end

  // Datapath control and result capture.
  always_comb begin
    ctl.cmd   = mrte_pkg::CELL_HOLD;
    ctl.phase = step_r[0];
    load_ent  = '{base: in_entry_base, length: in_entry_length, rtype: in_entry_type};
    count_nxt = count_r;
    step_nxt  = step_r;
    nb_nxt    = nb_r;
    nl_nxt    = nl_r;
    found_nxt = found_r;
    addr_nxt  = addr_r;
    fin       = 1'b0;
    fin_found = 1'b0;
    fin_addr  = '1;
    fin_ovf   = 1'b0;
    unique case (state_r)
      mrte_pkg::ST_IDLE: begin
        if (in_fire) begin
          step_nxt = '0;
          unique case (in_action)
            mrte_pkg::ACT_CLEAR: begin
              count_nxt = '0;
              fin       = 1'b1;
            end
            mrte_pkg::ACT_APPEND: begin
              if (count_r < FULL) begin
                ctl.cmd   = mrte_pkg::CELL_LOAD;
                count_nxt = count_r + CW'(1);
              end else begin
                fin_ovf = 1'b1;
              end
              fin = 1'b1;
            end
            mrte_pkg::ACT_CARVE: nl_nxt = '0;
            mrte_pkg::ACT_SORT:  step_nxt = '0;
            mrte_pkg::ACT_FIND: begin
              found_nxt = 1'b0;
              addr_nxt  = '1;
            end
            default: fin = 1'b1;
          endcase
        end
      end
      mrte_pkg::ST_CARVE: begin
        ctl.cmd  = mrte_pkg::CELL_ROT;
        step_nxt = step_r + CW'(1);
        if (head_res.split) begin
          nb_nxt = head_res.split_base;
          nl_nxt = head_res.split_len;
        end
      end
      mrte_pkg::ST_FIND: begin
        ctl.cmd  = mrte_pkg::CELL_ROT;
        step_nxt = step_r + CW'(1);
        if (head_res.match) begin
          found_nxt = 1'b1;
          addr_nxt  = head_res.match_addr;
        end
        if (last) begin
          fin       = 1'b1;
          fin_found = found_nxt;
          fin_addr  = found_nxt ? addr_nxt : '1;
        end
      end
      mrte_pkg::ST_SORT: begin
        ctl.cmd  = mrte_pkg::CELL_SORT;
        step_nxt = step_r + CW'(1);
        fin      = last;
      end
      mrte_pkg::ST_SPLIT: begin
        load_ent = '{base: nb_r, length: nl_r, rtype: ram_type_r};
        if (nl_r != 64'd0) begin
          if (count_r < FULL) begin
            ctl.cmd   = mrte_pkg::CELL_LOAD;
            count_nxt = count_r + CW'(1);
          end else begin
            fin_ovf = 1'b1;
          end
        end
        fin = 1'b1;
      end
      default: ctl.cmd = mrte_pkg::CELL_HOLD;
    endcase

    // Output register: a new result, or hold until taken.
    out_valid_nxt = out_valid_r && !out_ready;
    out_found_nxt = out_found_r;
    out_addr_nxt  = out_addr_r;
    out_total_nxt = out_total_r;
    out_ovf_nxt   = out_ovf_r;
    if (fin) begin
      out_valid_nxt = 1'b1;
      out_found_nxt = fin_found;
      out_addr_nxt  = fin_addr;
      out_total_nxt = 6'(count_nxt);
      out_ovf_nxt   = fin_ovf;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mrte_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      ram_type_r  <= 8'd1;
      rsvd_type_r <= 8'd2;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          mrte_pkg::CFG_RAM_TYPE:  ram_type_r  <= cfg_wdata;
          mrte_pkg::CFG_RSVD_TYPE: rsvd_type_r <= cfg_wdata;
          default:                 ram_type_r  <= ram_type_r;
        endcase
      end
    end
  end

  // Payload registers; the window bounds are page-rounded once per beat.
  always_ff @(posedge clk) begin
    step_r      <= step_nxt;
    nb_r        <= nb_nxt;
    nl_r        <= nl_nxt;
    found_r     <= found_nxt;
    addr_r      <= addr_nxt;
    out_found_r <= out_found_nxt;
    out_addr_r  <= out_addr_nxt;
    out_total_r <= out_total_nxt;
    out_ovf_r   <= out_ovf_nxt;
    if (in_fire) begin
      start_r <= in_range_start;
      end_r   <= in_range_end;
      rlo_r   <= (in_range_start + PG_MASK) & ~PG_MASK;
      rhi_r   <= in_range_end & ~PG_MASK;
      rsz_r   <= ({32'd0, in_request_size} + PG_MASK) & ~PG_MASK;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_space_address = out_addr_r;
  assign out_entry_total   = out_total_r;
  assign out_overflow      = out_ovf_r;

endmodule

// ===== rtl/core/mrte_chk.sv =====
// Port checker for the memory region table engine, bound to the top level.
module mrte_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_found,
  input logic [63:0] out_space_address,
  input logic        out_overflow
);

  // A held result keeps its address.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_space_address))
    else $error("result beat changed while stalled");

  // No new beat is taken while a result is still waiting.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !out_valid)
    else $error("input taken while a result is pending");

  // A miss reports the all-ones address.
  a_miss_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_space_address == 64'hFFFF_FFFF_FFFF_FFFF)
    else $error("miss without all-ones address");

  // Find never overflows.
  a_found_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_found && out_overflow))
    else $error("found and overflow both set");

endmodule

bind memory_region_table_engine_core mrte_chk u_mrte_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_found        (out_found),
  .out_space_address(out_space_address),
  .out_overflow     (out_overflow)
);
